// ===== rtl/core/cal_pkg.sv =====
`default_nettype none

package cal_pkg;

  typedef enum logic [1:0] {
    CMD_SCAN   = 2'd0,
    CMD_ADD    = 2'd1,
    CMD_DELETE = 2'd2,
    CMD_TICK   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_NOT_FOUND = 2'd1,
    STAT_PRESENT   = 2'd2,
    STAT_FULL      = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_SHIFT,
    S_DONE
  } seq_state_e;

  localparam int unsigned SlotW  = 4;
  localparam int unsigned CountW = 5;
  localparam logic [15:0] HoldTicksRst = 16'd5000;

  // Result of one command, handed from the sequencer to the output stage
  typedef struct packed {
    logic              valid;
    status_e           status;
    logic              hit;
    logic [SlotW-1:0]  slot;
    logic [CountW-1:0] count;
    logic              grant;
    logic              tick;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/core/cal_table.sv =====
`default_nettype none

module cal_table #(
  parameter int unsigned Depth = 16,
  parameter int unsigned IdxW  = 4
) (
  input  wire logic            clk_i,
  input  wire logic            we_i,
  input  wire logic [IdxW-1:0] waddr_i,
  input  wire logic [31:0]     wdata_i,
  input  wire logic            re_i,
  input  wire logic [IdxW-1:0] raddr_i,
  output logic      [31:0]     rdata_o
);

  logic [31:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/cal_seq.sv =====
`default_nettype none

module cal_seq #(
  parameter int unsigned Depth = 16,
  parameter int unsigned IdxW  = 4,
  parameter int unsigned CntW  = 5
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire cal_pkg::cmd_e        cmd_i,
  input  wire logic [31:0]          uid_i,
  output logic                      busy_o,
  // table port
  output logic                      we_o,
  output logic      [IdxW-1:0]      waddr_o,
  output logic      [31:0]          wdata_o,
  output logic                      re_o,
  output logic      [IdxW-1:0]      raddr_o,
  input  wire logic [31:0]          rdata_i,
  output cal_pkg::res_t             res_o
);

  localparam logic [CntW-1:0] DepthC = CntW'(Depth);
  localparam logic [CntW-1:0] OneC   = CntW'(1);

  cal_pkg::seq_state_e state_q, state_d;
  cal_pkg::cmd_e       cmd_q, cmd_d;
  logic [31:0]         uid_q, uid_d;
  logic [CntW-1:0]     count_q, count_d;
  logic [CntW-1:0]     scan_idx_q, scan_idx_d;
  logic [CntW-1:0]     rd_idx_q, rd_idx_d;
  logic                rd_pend_q, rd_pend_d;
  logic                found_q, found_d;
  logic [CntW-1:0]     pos_q, pos_d;
  logic [CntW-1:0]     shift_addr;

  logic issue, cmp_hit, last_rd, full, placed;

  assign issue      = scan_idx_q < count_q;
  assign cmp_hit    = rd_pend_q && (rdata_i == uid_q);
  assign last_rd    = (rd_idx_q + OneC) == count_q;
  assign full       = count_q >= DepthC;
  assign placed     = (cmd_q == cal_pkg::CMD_ADD) && !found_q && !full;
  assign shift_addr = rd_idx_q - OneC;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= cal_pkg::S_IDLE;
      count_q   <= '0;
      rd_pend_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      rd_pend_q <= rd_pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    uid_q      <= uid_d;
    scan_idx_q <= scan_idx_d;
    rd_idx_q   <= rd_idx_d;
    found_q    <= found_d;
    pos_q      <= pos_d;
  end

  // next state
  always_comb begin
    state_d    = state_q;
    cmd_d      = cmd_q;
    uid_d      = uid_q;
    count_d    = count_q;
    scan_idx_d = scan_idx_q;
    rd_idx_d   = rd_idx_q;
    rd_pend_d  = rd_pend_q;
    found_d    = found_q;
    pos_d      = pos_q;
    case (state_q)
      cal_pkg::S_IDLE: begin
        rd_pend_d = 1'b0;
        if (start_i) begin
          cmd_d      = cmd_i;
          uid_d      = uid_i;
          found_d    = 1'b0;
          pos_d      = '0;
          scan_idx_d = '0;
          if (cmd_i == cal_pkg::CMD_TICK || count_q == '0) begin
            state_d = cal_pkg::S_DONE;
          end else begin
            state_d = cal_pkg::S_SEARCH;
          end
        end
      end
      cal_pkg::S_SEARCH: begin
        // reads run one entry ahead of the compare
        if (cmp_hit) begin
          found_d    = 1'b1;
          pos_d      = rd_idx_q;
          rd_pend_d  = 1'b0;
          scan_idx_d = rd_idx_q + OneC;
          if (cmd_q == cal_pkg::CMD_DELETE) begin
            state_d = cal_pkg::S_SHIFT;
          end else begin
            state_d = cal_pkg::S_DONE;
          end
        end else if (rd_pend_q && last_rd) begin
          rd_pend_d = 1'b0;
          state_d   = cal_pkg::S_DONE;
        end else begin
          rd_pend_d  = issue;
          rd_idx_d   = scan_idx_q;
          scan_idx_d = scan_idx_q + CntW'(issue);
        end
      end
      cal_pkg::S_SHIFT: begin
        rd_pend_d  = issue;
        rd_idx_d   = scan_idx_q;
        scan_idx_d = scan_idx_q + CntW'(issue);
        if (!issue && !rd_pend_q) begin
          state_d = cal_pkg::S_DONE;
        end
      end
      cal_pkg::S_DONE: begin
        if (placed) begin
          count_d = count_q + OneC;
        end else if (cmd_q == cal_pkg::CMD_DELETE && found_q) begin
          count_d = count_q - OneC;
        end
        state_d = cal_pkg::S_IDLE;
      end
      default: begin
        state_d = cal_pkg::S_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    busy_o  = state_q != cal_pkg::S_IDLE;
    re_o    = 1'b0;
    raddr_o = scan_idx_q[IdxW-1:0];
    we_o    = 1'b0;
    waddr_o = count_q[IdxW-1:0];
    wdata_o = uid_q;
    res_o   = '0;
    case (state_q)
      cal_pkg::S_SEARCH: begin
        re_o = issue;
      end
      cal_pkg::S_SHIFT: begin
        re_o    = issue;
        we_o    = rd_pend_q;
        waddr_o = shift_addr[IdxW-1:0];
        wdata_o = rdata_i;
      end
      cal_pkg::S_DONE: begin
        we_o        = placed;
        res_o.valid = 1'b1;
        res_o.count = cal_pkg::CountW'(count_d);
        case (cmd_q)
          cal_pkg::CMD_SCAN, cal_pkg::CMD_DELETE: begin
            res_o.status = found_q ? cal_pkg::STAT_OK : cal_pkg::STAT_NOT_FOUND;
            res_o.hit    = found_q;
            res_o.slot   = cal_pkg::SlotW'(pos_q);
            res_o.grant  = found_q && (cmd_q == cal_pkg::CMD_SCAN);
          end
          cal_pkg::CMD_ADD: begin
            if (found_q) begin
              res_o.status = cal_pkg::STAT_PRESENT;
              res_o.hit    = 1'b1;
              res_o.slot   = cal_pkg::SlotW'(pos_q);
            end else if (full) begin
              res_o.status = cal_pkg::STAT_FULL;
            end else begin
              res_o.status = cal_pkg::STAT_OK;
              res_o.hit    = 1'b1;
              res_o.slot   = cal_pkg::SlotW'(count_q);
            end
          end
          default: begin
            res_o.status = cal_pkg::STAT_OK;
            res_o.tick   = 1'b1;
          end
        endcase
      end
      default: begin
        re_o = 1'b0;
      end
    endcase
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DepthC)
    else $error("entry count above table depth");

  a_done_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == cal_pkg::S_DONE |=> state_q == cal_pkg::S_IDLE)
    else $error("result state held longer than one cycle");

  a_shift_after_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == cal_pkg::S_SHIFT |-> found_q && cmd_q == cal_pkg::CMD_DELETE)
    else $error("compaction without a matching delete");

  a_shift_write_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == cal_pkg::S_SHIFT && rd_pend_q) |-> rd_idx_q > pos_q)
    else $error("compaction write below the removed slot");

  a_grant_on_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.grant |-> res_o.valid && res_o.hit)
    else $error("grant without a hit");

endmodule

`default_nettype wire

// ===== rtl/core/card_allowlist_with_door_hold.sv =====
// Channel  | Ports                                        | Transfer when
// ---------+----------------------------------------------+------------------------
// command  | start, busy, cmd_i, card_uid_i               | start && !busy
// result   | done_o, status_o, hit_o, slot_o,             | done_o (one cycle only)
//          | entry_count_o, door_is_open_o                |
// config   | hold_ticks_we_i, hold_ticks_i                | hold_ticks_we_i
//
// Tick, or any command on an empty table: busy only in the result state, done_o the next.
// Otherwise the search reads one entry per cycle and stops at the first hit or the last entry;
// busy covers the search and the result state, and done_o follows the result state.
// Delete at slot p then compacts, moving each later entry down by one slot.
// Reset clears count, door and hold counter; hold_ticks resets to 5000.
// The result is never stalled; a new command may start while done_o is high.
`default_nettype none

module card_allowlist_with_door_hold #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  cmd_i,
  input  wire logic [31:0] card_uid_i,
  input  wire logic        hold_ticks_we_i,
  input  wire logic [15:0] hold_ticks_i,
  output logic             done_o,
  output logic [1:0]       status_o,
  output logic             hit_o,
  output logic [3:0]       slot_o,
  output logic [4:0]       entry_count_o,
  output logic             door_is_open_o
);

  localparam int unsigned IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1);

  logic            we, re;
  logic [IdxW-1:0] waddr, raddr;
  logic [31:0]     wdata, rdata;
  cal_pkg::res_t   res;

  logic [15:0] hold_ticks_q;
  logic        door_q, door_d;
  logic [15:0] hold_q, hold_d;
  logic [16:0] hold_inc;
  logic        done_q;
  logic [1:0]  status_q;
  logic        hit_q;
  logic [3:0]  slot_q;
  logic [4:0]  count_q;

  cal_table #(
    .Depth (TABLE_DEPTH),
    .IdxW  (IdxW)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  cal_seq #(
    .Depth (TABLE_DEPTH),
    .IdxW  (IdxW),
    .CntW  (CntW)
  ) u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .cmd_i   (cal_pkg::cmd_e'(cmd_i)),
    .uid_i   (card_uid_i),
    .busy_o  (busy),
    .we_o    (we),
    .waddr_o (waddr),
    .wdata_o (wdata),
    .re_o    (re),
    .raddr_o (raddr),
    .rdata_i (rdata),
    .res_o   (res)
  );

  // door hold: counter compared one bit wider so a limit of all ones still closes
  assign hold_inc = {1'b0, hold_q} + 17'd1;

  always_comb begin
    door_d = door_q;
    hold_d = hold_q;
    if (res.valid && res.grant) begin
      door_d = 1'b1;
      hold_d = '0;
    end else if (res.valid && res.tick && door_q) begin
      if (hold_inc > {1'b0, hold_ticks_q}) begin
        door_d = 1'b0;
        hold_d = '0;
      end else begin
        hold_d = hold_inc[15:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_ticks_q <= cal_pkg::HoldTicksRst;
      door_q       <= 1'b0;
      hold_q       <= '0;
      done_q       <= 1'b0;
    end else begin
      if (hold_ticks_we_i) begin
        hold_ticks_q <= hold_ticks_i;
      end
      door_q <= door_d;
      hold_q <= hold_d;
      done_q <= res.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid) begin
      status_q <= res.status;
      hit_q    <= res.hit;
      slot_q   <= res.slot;
      count_q  <= res.count;
    end
  end

  assign done_o         = done_q;
  assign status_o       = status_q;
  assign hit_o          = hit_q;
  assign slot_o         = slot_q;
  assign entry_count_o  = count_q;
  assign door_is_open_o = door_q;

  a_door_closed_hold_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !door_q |-> hold_q == '0)
    else $error("hold counter running with door closed");

  a_grant_opens: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.valid && res.grant |=> door_q && hold_q == '0)
    else $error("granted scan did not open the door");

  a_door_change_on_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(door_q) |-> $past(res.valid))
    else $error("door changed without a command result");

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
`default_nettype none

module testbench;

  localparam int unsigned DEPTH = 16;
  localparam int unsigned QUIET_LIMIT = 2000;

  typedef struct {
    cal_pkg::cmd_e cmd;
    logic [31:0]   uid;
  } door_cmd_t;

  typedef struct {
    cal_pkg::status_e status;
    logic             hit;
    logic [3:0]       slot;
    logic [4:0]       count;
    logic             door;
  } door_result_t;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          start = 1'b0;
  logic          busy;
  cal_pkg::cmd_e cmd_r = cal_pkg::CMD_SCAN;
  logic [31:0]   uid_r = '0;
  logic          hold_we_r = 1'b0;
  logic [15:0]   hold_val_r = '0;
  logic          done_o;
  logic [1:0]    status_o;
  logic          hit_o;
  logic [3:0]    slot_o;
  logic [4:0]    entry_count_o;
  logic          door_is_open_o;

  card_allowlist_with_door_hold #(
    .TABLE_DEPTH(DEPTH)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .cmd_i          (cmd_r),
    .card_uid_i     (uid_r),
    .hold_ticks_we_i(hold_we_r),
    .hold_ticks_i   (hold_val_r),
    .done_o         (done_o),
    .status_o       (status_o),
    .hit_o          (hit_o),
    .slot_o         (slot_o),
    .entry_count_o  (entry_count_o),
    .door_is_open_o (door_is_open_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Shadow of the allowlist state
  logic [31:0] card_ids [DEPTH];
  int          n_cards = 0;
  logic        door_shadow = 1'b0;
  logic [15:0] hold_cnt = '0;
  logic [15:0] hold_limit = 16'd5000;

  door_cmd_t    cmd_queue [$];
  door_result_t result_queue [$];
  int           idle_pct = 0;
  int           err_cnt = 0;
  int           quiet_cycles = 0;
  logic [31:0]  card_pool [24];

  function automatic door_result_t apply_door_cmd(cal_pkg::cmd_e c, logic [31:0] uid);
    door_result_t r;
    int pos;
    r = '{cal_pkg::STAT_OK, 1'b0, 4'd0, 5'd0, 1'b0};
    pos = -1;
    for (int i = 0; i < n_cards; i++) begin
      if (pos < 0 && card_ids[i] == uid) pos = i;
    end
    case (c)
      cal_pkg::CMD_SCAN: begin
        if (pos >= 0) begin
          r.hit = 1'b1;
          r.slot = 4'(pos);
          door_shadow = 1'b1;
          hold_cnt = '0;
        end else begin
          r.status = cal_pkg::STAT_NOT_FOUND;
        end
      end
      cal_pkg::CMD_ADD: begin
        if (pos >= 0) begin
          r.status = cal_pkg::STAT_PRESENT;
          r.hit = 1'b1;
          r.slot = 4'(pos);
        end else if (n_cards >= DEPTH) begin
          r.status = cal_pkg::STAT_FULL;
        end else begin
          card_ids[n_cards] = uid;
          r.hit = 1'b1;
          r.slot = 4'(n_cards);
          n_cards++;
        end
      end
      cal_pkg::CMD_DELETE: begin
        if (pos >= 0) begin
          r.hit = 1'b1;
          r.slot = 4'(pos);
          for (int i = pos; i < n_cards - 1; i++) card_ids[i] = card_ids[i + 1];
          n_cards--;
        end else begin
          r.status = cal_pkg::STAT_NOT_FOUND;
        end
      end
      default: begin
        // counter compared one bit wider so a limit of 65535 still closes
        if (door_shadow) begin
          if (int'(hold_cnt) + 1 > int'(hold_limit)) begin
            door_shadow = 1'b0;
            hold_cnt = '0;
          end else begin
            hold_cnt = hold_cnt + 16'd1;
          end
        end
      end
    endcase
    r.count = 5'(n_cards);
    r.door = door_shadow;
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    err_cnt++;
  endtask

  // Driver: a command transfer happens when start && !busy
  always @(posedge clk_i or negedge rst_ni) begin : driver
    door_cmd_t nxt;
    if (!rst_ni) begin
      start <= 1'b0;
      cmd_r <= cal_pkg::CMD_SCAN;
      uid_r <= '0;
    end else begin
      if (start && !busy) result_queue.push_back(apply_door_cmd(cmd_r, uid_r));
      if (!(start && busy)) begin
        if (cmd_queue.size() != 0 && $urandom_range(99) >= idle_pct) begin
          nxt = cmd_queue.pop_front();
          start <= 1'b1;
          cmd_r <= nxt.cmd;
          uid_r <= nxt.uid;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every done_o pulse is one result transfer
  always @(posedge clk_i) begin : monitor
    door_result_t want;
    if (rst_ni && done_o) begin
      if (result_queue.size() == 0) begin
        report_mismatch("result with nothing outstanding");
      end else begin
        want = result_queue.pop_front();
        if (status_o !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", status_o, want.status));
        if (hit_o !== want.hit)
          report_mismatch($sformatf("hit %0b, want %0b", hit_o, want.hit));
        if (slot_o !== want.slot)
          report_mismatch($sformatf("slot %0d, want %0d", slot_o, want.slot));
        if (entry_count_o !== want.count)
          report_mismatch($sformatf("count %0d, want %0d", entry_count_o, want.count));
        if (door_is_open_o !== want.door)
          report_mismatch($sformatf("door %0b, want %0b", door_is_open_o, want.door));
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || done_o) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Watchdog: no transfer for %0d cycles", quiet_cycles);
        $display("Verification failed");
        $finish;
      end
    end
  end

  task automatic push_cmd(cal_pkg::cmd_e c, logic [31:0] u);
    door_cmd_t it;
    it.cmd = c;
    it.uid = u;
    cmd_queue.push_back(it);
  endtask

  task automatic wait_drained();
    while (cmd_queue.size() != 0 || start || result_queue.size() != 0)
      @(posedge clk_i);
  endtask

  // block is idle here; the write is registered from hold_we_r and hold_val_r
  task automatic write_hold(logic [15:0] v);
    @(posedge clk_i);
    hold_we_r <= 1'b1;
    hold_val_r <= v;
    hold_limit = v;
    @(posedge clk_i);
    hold_we_r <= 1'b0;
  endtask

  task automatic run_random(int n, int idle, int scan_w, int add_w, int del_w);
    int r;
    logic [31:0] u;
    idle_pct = idle;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(99);
      // mostly known cards so that hits, duplicates and a full table occur
      if ($urandom_range(99) < 80) u = card_pool[$urandom_range(23)];
      else u = $urandom;
      if (r < scan_w) push_cmd(cal_pkg::CMD_SCAN, u);
      else if (r < scan_w + add_w) push_cmd(cal_pkg::CMD_ADD, u);
      else if (r < scan_w + add_w + del_w) push_cmd(cal_pkg::CMD_DELETE, u);
      else push_cmd(cal_pkg::CMD_TICK, $urandom);
    end
    wait_drained();
  endtask

  initial begin
    for (int i = 0; i < DEPTH; i++) card_ids[i] = '0;
    for (int i = 0; i < 24; i++) card_pool[i] = $urandom;
    card_pool[0] = 32'h0000_0000;
    card_pool[1] = 32'hFFFF_FFFF;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: misses on empty table, extreme ids, duplicate, grant, full table
    write_hold(16'd0);
    push_cmd(cal_pkg::CMD_SCAN, 32'h0000_0000);
    push_cmd(cal_pkg::CMD_DELETE, 32'hFFFF_FFFF);
    push_cmd(cal_pkg::CMD_TICK, 32'h0000_0000);
    push_cmd(cal_pkg::CMD_ADD, 32'h0000_0000);
    push_cmd(cal_pkg::CMD_ADD, 32'hFFFF_FFFF);
    push_cmd(cal_pkg::CMD_ADD, 32'hFFFF_FFFF);
    push_cmd(cal_pkg::CMD_SCAN, 32'hFFFF_FFFF);
    push_cmd(cal_pkg::CMD_TICK, 32'hFFFF_FFFF);
    for (int i = 0; i < DEPTH - 2; i++)
      push_cmd(cal_pkg::CMD_ADD, 32'h8000_0001 + i * 32'h1111_1111);
    push_cmd(cal_pkg::CMD_ADD, 32'h1234_5678);
    push_cmd(cal_pkg::CMD_ADD, 32'h0000_0000);
    push_cmd(cal_pkg::CMD_DELETE, 32'h0000_0000);
    push_cmd(cal_pkg::CMD_SCAN, 32'h8000_0001 + (DEPTH - 3) * 32'h1111_1111);
    wait_drained();

    // largest hold: the door stays open through a run of ticks
    write_hold(16'hFFFF);
    push_cmd(cal_pkg::CMD_SCAN, 32'hFFFF_FFFF);
    for (int i = 0; i < 20; i++) push_cmd(cal_pkg::CMD_TICK, $urandom);
    wait_drained();

    write_hold(16'd3);
    run_random(130, 0, 30, 40, 15);
    write_hold(16'd0);
    run_random(120, 77, 35, 25, 25);
    write_hold(16'($urandom_range(1, 12)));
    run_random(120, 0, 30, 20, 25);
    write_hold(16'd1);
    run_random(140, 31, 30, 35, 20);

    repeat (50) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
